// ===== rtl/sbba_pkg.sv =====
package sbba_pkg;

   localparam int COORD_WIDTH = 32;
   localparam int FIELD_W     = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_W      = 2 * FIELD_W;
   localparam int PART_W      = PROD_W - FRAC_BITS;
   // wide enough for two floored products plus a shift, and for any enlarge step
   localparam int WIDE_W      = (COORD_WIDTH + 2 > PART_W + 2) ? COORD_WIDTH + 2 : PART_W + 2;
   localparam int INFL_W      = 31;
   localparam int DELTA_W     = 32;
   localparam int CAP_W       = 2;
   localparam int KIND_W      = 2;
   localparam int NUM_BOXES   = 3;
   localparam int MUL_CNT_W   = 3;
   localparam int CORNER_W    = 2;
   localparam int OUT_W       = 32;
   localparam int IN_DATA_W   = 10 * FIELD_W;
   localparam int OUT_DATA_W  = 4 * OUT_W;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int FIFO_DEPTH  = 2;
   localparam int FIFO_PTR_W  = 1;
   localparam int FIFO_CNT_W  = 2;

   localparam logic [FIELD_W-1:0]   SQRT2_Q16  = FIELD_W'(92682);
   localparam logic [PROD_W-1:0]    ROUND_HALF = PROD_W'(1) << (FRAC_BITS - 1);
   localparam logic [MUL_CNT_W-1:0] MUL_LAST   = '1;
   localparam logic [CORNER_W-1:0]  CORNER_LAST = '1;

   localparam logic [KIND_W-1:0] KIND_FILL = 2'd0;
   localparam logic [KIND_W-1:0] KIND_JOIN = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CAP  = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;

   localparam logic [CAP_W-1:0] CAP_BUTT   = 2'd0;
   localparam logic [CAP_W-1:0] CAP_ROUND  = 2'd1;
   localparam logic [CAP_W-1:0] CAP_EXTEND = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_STROKE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_JOIN   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CAP    = 2'd2;

   typedef logic signed [COORD_WIDTH-1:0] coord_type;
   typedef logic signed [WIDE_W-1:0]      wide_type;

   typedef struct packed {
      logic [INFL_W-1:0] line_pad;
      logic [INFL_W-1:0] corner_pad;
      logic [CAP_W-1:0]  end_mode;
   } cfg_type;

   typedef struct packed {
      logic                      use_rect;
      logic                      last;
      logic [KIND_W-1:0]         kind;
      logic signed [FIELD_W-1:0] x0;
      logic signed [FIELD_W-1:0] y0;
      logic signed [FIELD_W-1:0] x1;
      logic signed [FIELD_W-1:0] y1;
      logic signed [FIELD_W-1:0] mxx;
      logic signed [FIELD_W-1:0] mxy;
      logic signed [FIELD_W-1:0] myx;
      logic signed [FIELD_W-1:0] myy;
      logic signed [FIELD_W-1:0] tx;
      logic signed [FIELD_W-1:0] ty;
   } item_type;

   function automatic coord_type sat_coord(input wide_type v);
      wide_type hi;
      wide_type lo;
      hi = {{(WIDE_W - COORD_WIDTH + 1){1'b0}}, {(COORD_WIDTH - 1){1'b1}}};
      lo = ~hi;
      if (v > hi) begin
         return hi[COORD_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[COORD_WIDTH-1:0];
      end
      return v[COORD_WIDTH-1:0];
   endfunction

   function automatic logic [OUT_W-1:0] sat_out(input coord_type v);
      wide_type w;
      wide_type hi;
      wide_type lo;
      w  = WIDE_W'(v);
      hi = {{(WIDE_W - OUT_W + 1){1'b0}}, {(OUT_W - 1){1'b1}}};
      lo = ~hi;
      if (w > hi) begin
         return hi[OUT_W-1:0];
      end else if (w < lo) begin
         return lo[OUT_W-1:0];
      end
      return w[OUT_W-1:0];
   endfunction

endpackage

// ===== rtl/sbba_front.sv =====
module sbba_front import sbba_pkg::*; (
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [IN_DATA_W-1:0] req_tdata,
   input  logic [KIND_W-1:0]    req_tuser,
   input  logic                 req_tlast,
   input  logic [CAP_W-1:0]     end_mode,
   input  logic                 q_full,
   output logic                 push,
   output item_type             push_item
);

   logic empty_rect;
   logic kind_off;

   assign req_tready = !q_full;
   assign push       = req_tvalid && !q_full;

   always_comb begin
      push_item.last = req_tlast;
      push_item.kind = req_tuser;
      push_item.x0   = req_tdata[0*FIELD_W +: FIELD_W];
      push_item.y0   = req_tdata[1*FIELD_W +: FIELD_W];
      push_item.x1   = req_tdata[2*FIELD_W +: FIELD_W];
      push_item.y1   = req_tdata[3*FIELD_W +: FIELD_W];
      push_item.mxx  = req_tdata[4*FIELD_W +: FIELD_W];
      push_item.mxy  = req_tdata[5*FIELD_W +: FIELD_W];
      push_item.myx  = req_tdata[6*FIELD_W +: FIELD_W];
      push_item.myy  = req_tdata[7*FIELD_W +: FIELD_W];
      push_item.tx   = req_tdata[8*FIELD_W +: FIELD_W];
      push_item.ty   = req_tdata[9*FIELD_W +: FIELD_W];
      // degenerate boxes with min equal to max still count
      empty_rect = (push_item.x1 < push_item.x0) || (push_item.y1 < push_item.y0);
      kind_off   = (req_tuser == KIND_NONE) ||
                   ((req_tuser == KIND_CAP) && (end_mode == CAP_BUTT));
      push_item.use_rect = !empty_rect && !kind_off;
   end

endmodule

// ===== rtl/sbba_fifo.sv =====
module sbba_fifo import sbba_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   output logic     valid,
   output item_type head,
   input  logic     pop
);

   localparam logic [FIFO_PTR_W-1:0] PTR_LAST = FIFO_PTR_W'(FIFO_DEPTH - 1);

   item_type slot_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0] count_ff, count_in;

   assign full  = (count_ff == FIFO_CNT_W'(FIFO_DEPTH));
   assign valid = (count_ff != '0);
   assign head  = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff + FIFO_CNT_W'(push) - FIFO_CNT_W'(pop);
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// ===== rtl/sbba_back.sv =====
module sbba_back import sbba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cfg_type               cfg,
   input  logic                  q_valid,
   input  item_type              q_item,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tuser
);

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_MUL   = 7'b0000010,
      ST_PT    = 7'b0000100,
      ST_ADD   = 7'b0001000,
      ST_CAP   = 7'b0010000,
      ST_GROW  = 7'b0100000,
      ST_MERGE = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [MUL_CNT_W-1:0] cnt_ff, cnt_in;

   // floored partial products, one pair per matrix entry (index = corner bit)
   logic signed [PART_W-1:0] p_xx_ff [2];
   logic signed [PART_W-1:0] p_xy_ff [2];
   logic signed [PART_W-1:0] p_yx_ff [2];
   logic signed [PART_W-1:0] p_yy_ff [2];
   logic signed [PART_W-1:0] p_xx_in [2];
   logic signed [PART_W-1:0] p_xy_in [2];
   logic signed [PART_W-1:0] p_yx_in [2];
   logic signed [PART_W-1:0] p_yy_in [2];

   coord_type pt_x_ff, pt_x_in;
   coord_type pt_y_ff, pt_y_in;
   logic [DELTA_W-1:0] cap_d_ff, cap_d_in;

   coord_type acc_min_x_ff [NUM_BOXES];
   coord_type acc_min_y_ff [NUM_BOXES];
   coord_type acc_max_x_ff [NUM_BOXES];
   coord_type acc_max_y_ff [NUM_BOXES];
   coord_type acc_min_x_in [NUM_BOXES];
   coord_type acc_min_y_in [NUM_BOXES];
   coord_type acc_max_x_in [NUM_BOXES];
   coord_type acc_max_y_in [NUM_BOXES];
   logic [NUM_BOXES-1:0] acc_empty_ff, acc_empty_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [OUT_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_empty_ff, rsp_empty_in;

   logic signed [FIELD_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0]  mul_p;
   logic signed [PART_W-1:0]  mul_part;
   logic [CORNER_W-1:0]       corner;
   logic [KIND_W-1:0]         box;
   wide_type                  sum_x, sum_y;
   logic [DELTA_W-1:0]        grow_d [NUM_BOXES];
   logic [PROD_W-1:0]         cap_round;
   logic                      out_free;
   logic                      merge_fire;
   logic                      m_any;
   coord_type                 m_min_x, m_min_y, m_max_x, m_max_y;

   assign corner     = cnt_ff[CORNER_W-1:0];
   assign box        = q_item.kind;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign merge_fire = (state_ff == ST_MERGE) && out_free;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_empty_ff;

   // one shared multiplier: matrix terms while in ST_MUL, sqrt2 inflate in ST_CAP
   always_comb begin
      if (state_ff == ST_CAP) begin
         mul_a = signed'(FIELD_W'(cfg.line_pad));
         mul_b = signed'(SQRT2_Q16);
      end else begin
         unique case (cnt_ff[2:1])
            2'd0: mul_a = q_item.mxx;
            2'd1: mul_a = q_item.mxy;
            2'd2: mul_a = q_item.myx;
            2'd3: mul_a = q_item.myy;
            default: mul_a = q_item.mxx;
         endcase
         if (cnt_ff[1]) begin
            mul_b = cnt_ff[0] ? q_item.y1 : q_item.y0;
         end else begin
            mul_b = cnt_ff[0] ? q_item.x1 : q_item.x0;
         end
      end
      mul_p    = mul_a * mul_b;
      mul_part = mul_p[PROD_W-1:FRAC_BITS];
   end

   assign sum_x = WIDE_W'(p_xx_ff[corner[0]]) + WIDE_W'(p_xy_ff[corner[1]]) +
                  WIDE_W'(q_item.tx);
   assign sum_y = WIDE_W'(p_yx_ff[corner[0]]) + WIDE_W'(p_yy_ff[corner[1]]) +
                  WIDE_W'(q_item.ty);

   assign cap_round = (unsigned'(mul_p) + ROUND_HALF) >> FRAC_BITS;
   assign grow_d[0] = DELTA_W'(cfg.line_pad);
   assign grow_d[1] = DELTA_W'(cfg.corner_pad);
   assign grow_d[2] = cap_d_ff;

   // union of the non-empty boxes
   always_comb begin
      m_any   = 1'b0;
      m_min_x = '0;
      m_min_y = '0;
      m_max_x = '0;
      m_max_y = '0;
      for (int b = 0; b < NUM_BOXES; b++) begin
         if (!acc_empty_ff[b]) begin
            if (!m_any || acc_min_x_ff[b] < m_min_x) m_min_x = acc_min_x_ff[b];
            if (!m_any || acc_min_y_ff[b] < m_min_y) m_min_y = acc_min_y_ff[b];
            if (!m_any || acc_max_x_ff[b] > m_max_x) m_max_x = acc_max_x_ff[b];
            if (!m_any || acc_max_y_ff[b] > m_max_y) m_max_y = acc_max_y_ff[b];
            m_any = 1'b1;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      p_xx_in      = p_xx_ff;
      p_xy_in      = p_xy_ff;
      p_yx_in      = p_yx_ff;
      p_yy_in      = p_yy_ff;
      pt_x_in      = pt_x_ff;
      pt_y_in      = pt_y_ff;
      cap_d_in     = cap_d_ff;
      acc_min_x_in = acc_min_x_ff;
      acc_min_y_in = acc_min_y_ff;
      acc_max_x_in = acc_max_x_ff;
      acc_max_y_in = acc_max_y_ff;
      acc_empty_in = acc_empty_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_empty_in = rsp_empty_ff;
      q_pop        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               if (q_item.use_rect) begin
                  state_in = ST_MUL;
                  cnt_in   = '0;
               end else if (q_item.last) begin
                  state_in = ST_CAP;
               end else begin
                  q_pop = 1'b1;
               end
            end
         end
         ST_MUL: begin
            unique case (cnt_ff[2:1])
               2'd0: p_xx_in[cnt_ff[0]] = mul_part;
               2'd1: p_xy_in[cnt_ff[0]] = mul_part;
               2'd2: p_yx_in[cnt_ff[0]] = mul_part;
               2'd3: p_yy_in[cnt_ff[0]] = mul_part;
               default: p_xx_in[cnt_ff[0]] = mul_part;
            endcase
            if (cnt_ff == MUL_LAST) begin
               cnt_in   = '0;
               state_in = ST_PT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_PT: begin
            pt_x_in  = sat_coord(sum_x);
            pt_y_in  = sat_coord(sum_y);
            state_in = ST_ADD;
         end
         ST_ADD: begin
            if (acc_empty_ff[box]) begin
               acc_min_x_in[box] = pt_x_ff;
               acc_max_x_in[box] = pt_x_ff;
               acc_min_y_in[box] = pt_y_ff;
               acc_max_y_in[box] = pt_y_ff;
               acc_empty_in[box] = 1'b0;
            end else begin
               if (pt_x_ff < acc_min_x_ff[box]) acc_min_x_in[box] = pt_x_ff;
               if (pt_x_ff > acc_max_x_ff[box]) acc_max_x_in[box] = pt_x_ff;
               if (pt_y_ff < acc_min_y_ff[box]) acc_min_y_in[box] = pt_y_ff;
               if (pt_y_ff > acc_max_y_ff[box]) acc_max_y_in[box] = pt_y_ff;
            end
            if (corner == CORNER_LAST) begin
               cnt_in = '0;
               if (q_item.last) begin
                  state_in = ST_CAP;
               end else begin
                  q_pop    = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_PT;
            end
         end
         ST_CAP: begin
            cap_d_in = (cfg.end_mode == CAP_EXTEND) ? cap_round[DELTA_W-1:0]
                                                    : DELTA_W'(cfg.line_pad);
            state_in = ST_GROW;
         end
         ST_GROW: begin
            for (int b = 0; b < NUM_BOXES; b++) begin
               if (!acc_empty_ff[b]) begin
                  acc_min_x_in[b] = sat_coord(WIDE_W'(acc_min_x_ff[b]) -
                                              signed'(WIDE_W'(grow_d[b])));
                  acc_min_y_in[b] = sat_coord(WIDE_W'(acc_min_y_ff[b]) -
                                              signed'(WIDE_W'(grow_d[b])));
                  acc_max_x_in[b] = sat_coord(WIDE_W'(acc_max_x_ff[b]) +
                                              signed'(WIDE_W'(grow_d[b])));
                  acc_max_y_in[b] = sat_coord(WIDE_W'(acc_max_y_ff[b]) +
                                              signed'(WIDE_W'(grow_d[b])));
               end
            end
            state_in = ST_MERGE;
         end
         ST_MERGE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sat_out(m_max_y), sat_out(m_max_x),
                               sat_out(m_min_y), sat_out(m_min_x)};
               rsp_empty_in = !m_any;
               acc_empty_in = '1;
               q_pop        = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         acc_empty_ff <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_empty_ff <= acc_empty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      p_xx_ff      <= p_xx_in;
      p_xy_ff      <= p_xy_in;
      p_yx_ff      <= p_yx_in;
      p_yy_ff      <= p_yy_in;
      pt_x_ff      <= pt_x_in;
      pt_y_ff      <= pt_y_in;
      cap_d_ff     <= cap_d_in;
      acc_min_x_ff <= acc_min_x_in;
      acc_min_y_ff <= acc_min_y_in;
      acc_max_x_ff <= acc_max_x_in;
      acc_max_y_ff <= acc_max_y_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_empty_ff <= rsp_empty_in;
   end

   a_pop_needs_item: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_clear_after_result: assert property (@(posedge clock) disable iff (reset)
      merge_fire |=> (acc_empty_ff == '1))
      else $error("boxes not cleared after result");

   a_result_from_merge: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(merge_fire))
      else $error("result raised without a merge");

   a_mul_on_used_rect: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MUL) |-> (q_valid && q_item.use_rect))
      else $error("transform running on an ignored request");

endmodule

// ===== rtl/stroked_bbox_accumulator.sv =====
// Bounding box of a stroked, transformed set of rectangles.
// req channel: one request per rectangle. tdata carries the rectangle edges,
// the 2x2 matrix and the translation (Q16.16), tuser the box kind, tlast marks
// the final rectangle of a set. rsp channel: one response per set, sent after
// the tlast request, with the union box in tdata and the empty flag in tuser.
// csr channel: register writes (stroke half width, join pad, cap mode),
// always ready, to be issued only while no set is in flight.
// Back end: a request that adds nothing takes only a dispatch step; a
// contributing rectangle takes a dispatch step, then the single 32x32
// multiplier (8 products, one per cycle) and 4 corners of a point step
// and an add step each. The tlast request then runs the sqrt2 scale,
// enlarge and union steps before the response.
// A 2-entry queue lets requests be taken while the back end is busy.
// Reset clears the queue, the sequencer and all three boxes to empty, and the
// configuration registers to zero. If rsp_tready stays low, the response is
// held and the next set stalls only at its own union step.
module stroked_bbox_accumulator import sbba_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // rect_min_x, rect_min_y, rect_max_x, rect_max_y, mat_xx, mat_xy, mat_yx,
   // mat_yy, shift_x, shift_y
   input  logic [IN_DATA_W-1:0]  req_tdata,
   // box_kind
   input  logic [KIND_W-1:0]     req_tuser,
   input  logic                  req_tlast,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_min_x, out_min_y, out_max_x, out_max_y
   output logic [OUT_DATA_W-1:0] rsp_tdata,
   // out_empty
   output logic                  rsp_tuser,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type  cfg_ff, cfg_in;
   logic     q_full, q_valid, q_push, q_pop;
   item_type push_item, q_item;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_STROKE: cfg_in.line_pad   = csr_data[INFL_W-1:0];
            CSR_JOIN:   cfg_in.corner_pad = csr_data[INFL_W-1:0];
            CSR_CAP:    cfg_in.end_mode   = csr_data[CAP_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   sbba_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .end_mode   (cfg_ff.end_mode),
      .q_full     (q_full),
      .push       (q_push),
      .push_item  (push_item)
   );

   sbba_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (push_item),
      .full      (q_full),
      .valid     (q_valid),
      .head      (q_item),
      .pop       (q_pop)
   );

   sbba_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
